// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Escape modes, result status codes, the command word passed from the
// front end to the back end, and the character helper functions.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [2:0] {
      MODE_PLAIN = 3'd0,
      MODE_ESC   = 3'd1,
      MODE_HEX1  = 3'd2,
      MODE_HEX2  = 3'd3,
      MODE_HEX3  = 3'd4,
      MODE_HEX4  = 3'd5
   } mode_type;

   typedef enum logic [1:0] {
      ST_BYTE  = 2'd0,
      ST_CLOSE = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   localparam int unsigned SHOWN_BITS = 16;
   localparam int unsigned QDEPTH     = 4;
   localparam int unsigned QPTR_BITS  = 2;
   localparam int unsigned QFILL_BITS = 3;

   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_U     = 8'h75;
   localparam logic [7:0] CH_NUL   = 8'h00;

   localparam logic [15:0] UTF_ONE_MAX = 16'h007F;
   localparam logic [15:0] UTF_TWO_MAX = 16'h07FF;
   localparam logic [7:0]  LEAD2_MASK  = 8'h1F;
   localparam logic [7:0]  LEAD2_TAG   = 8'hC0;
   localparam logic [7:0]  LEAD3_MASK  = 8'h0F;
   localparam logic [7:0]  LEAD3_TAG   = 8'hE0;
   localparam logic [7:0]  CONT_MASK   = 8'h3F;
   localparam logic [7:0]  CONT_TAG    = 8'h80;

   // one command yields count results (one to three), taken in order
   typedef struct packed {
      logic [7:0]            byte0;
      logic [7:0]            byte1;
      logic [7:0]            byte2;
      logic [1:0]            count;
      status_type            status;
      logic [SHOWN_BITS-1:0] line;
   } cmd_type;

   // {valid, digit value}
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   // zero means the letter is not a single-byte escape
   function automatic logic [7:0] escape_map(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         8'h22: r = 8'h22;
         8'h27: r = 8'h27;
         8'h2F: r = 8'h2F;
         8'h5C: r = 8'h5C;
         8'h61: r = 8'h07;
         8'h62: r = 8'h08;
         8'h66: r = 8'h0C;
         8'h6E: r = 8'h0A;
         8'h72: r = 8'h0D;
         8'h74: r = 8'h09;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ----- src/jsu_ifs.sv -----
// ----------------------------------------------------------------------------
// jsu_req_if / jsu_rsp_if: valid/ready channels of the string unescaper
// A transaction moves when valid and ready are both high at a clock edge.
// ----------------------------------------------------------------------------
interface jsu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface jsu_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  out_byte;
   logic [1:0]  status;
   logic        last;
   logic [15:0] line_number;

   modport source (output valid, output out_byte, output status, output last,
                   output line_number, input ready);
   modport sink (input valid, input out_byte, input status, input last,
                 input line_number, output ready);
endinterface

// ----- src/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front: input decode of the string unescaper
// Tracks the escape mode, gathers \u hex digits, counts raw line feeds and
// turns every accepted byte into at most one command for the back end.
// ----------------------------------------------------------------------------
module jsu_front import jsu_pkg::*; #(
   parameter int unsigned LINE_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   jsu_req_if.sink      req_bus,
   input  logic         q_full,
   output logic         push,
   output cmd_type      push_cmd
);

   mode_type              mode_ff, mode_in;
   logic [15:0]           cp_ff, cp_in;
   logic [LINE_BITS-1:0]  line_ff, line_in;
   logic [SHOWN_BITS-1:0] line_shown;
   logic                  accept;
   logic [7:0]            c;
   logic [4:0]            hv;
   logic [7:0]            esc;
   logic [15:0]           cp_next;
   cmd_type               cmd;

   assign req_bus.ready = !q_full;
   assign accept  = req_bus.valid && req_bus.ready;
   assign c       = req_bus.in_byte;
   assign hv      = hex_value(c);
   assign esc     = escape_map(c);
   assign cp_next = {cp_ff[11:0], hv[3:0]};

   // next state
   always_comb begin
      mode_in = mode_ff;
      cp_in   = cp_ff;
      line_in = line_ff;
      if (accept) begin
         if (c == CH_NUL) begin
            mode_in = MODE_PLAIN;
            cp_in   = 16'h0000;
         end else begin
            unique case (mode_ff)
               MODE_ESC: begin
                  if (esc != 8'h00) begin
                     mode_in = MODE_PLAIN;
                  end else if (c == CH_U) begin
                     mode_in = MODE_HEX1;
                     cp_in   = 16'h0000;
                  end else begin
                     mode_in = MODE_PLAIN;
                     cp_in   = 16'h0000;
                  end
               end
               MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
                  if (!hv[4]) begin
                     mode_in = MODE_PLAIN;
                     cp_in   = 16'h0000;
                  end else begin
                     cp_in = cp_next;
                     unique case (mode_ff)
                        MODE_HEX1: mode_in = MODE_HEX2;
                        MODE_HEX2: mode_in = MODE_HEX3;
                        default:   mode_in = MODE_HEX4;
                     endcase
                  end
               end
               MODE_HEX4: begin
                  mode_in = MODE_PLAIN;
                  cp_in   = 16'h0000;
               end
               default: begin
                  mode_in = (c == CH_BSLASH) ? MODE_ESC : MODE_PLAIN;
                  if (c == CH_QUOTE) begin
                     cp_in = 16'h0000;
                  end
                  if (c == CH_LF && line_ff != {LINE_BITS{1'b1}}) begin
                     line_in = line_ff + 1'b1;
                  end
               end
            endcase
         end
      end
   end

   // clamp the count to the 16-bit field
   generate
      if (LINE_BITS > SHOWN_BITS) begin : g_wide
         assign line_shown = (|line_in[LINE_BITS-1:SHOWN_BITS]) ?
                             {SHOWN_BITS{1'b1}} : line_in[SHOWN_BITS-1:0];
      end else begin : g_narrow
         assign line_shown = SHOWN_BITS'(line_in);
      end
   endgenerate

   // command output
   always_comb begin
      cmd.byte0  = 8'h00;
      cmd.byte1  = 8'h00;
      cmd.byte2  = 8'h00;
      cmd.count  = 2'd0;
      cmd.status = ST_BYTE;
      cmd.line   = line_shown;
      if (c == CH_NUL) begin
         cmd.count  = 2'd1;
         cmd.status = ST_ERROR;
      end else begin
         unique case (mode_ff)
            MODE_ESC: begin
               if (esc != 8'h00) begin
                  cmd.byte0 = esc;
                  cmd.count = 2'd1;
               end else if (c != CH_U) begin
                  cmd.count  = 2'd1;
                  cmd.status = ST_ERROR;
               end
            end
            MODE_HEX1, MODE_HEX2, MODE_HEX3: begin
               if (!hv[4]) begin
                  cmd.count  = 2'd1;
                  cmd.status = ST_ERROR;
               end
            end
            MODE_HEX4: begin
               if (!hv[4]) begin
                  cmd.count  = 2'd1;
                  cmd.status = ST_ERROR;
               end else if (cp_next <= UTF_ONE_MAX) begin
                  cmd.byte0 = cp_next[7:0];
                  cmd.count = 2'd1;
               end else if (cp_next <= UTF_TWO_MAX) begin
                  cmd.byte0 = (cp_next[13:6] & LEAD2_MASK) | LEAD2_TAG;
                  cmd.byte1 = (cp_next[7:0] & CONT_MASK) | CONT_TAG;
                  cmd.count = 2'd2;
               end else begin
                  cmd.byte0 = (cp_next[15:8] >> 4) | LEAD3_TAG;
                  cmd.byte1 = (cp_next[13:6] & CONT_MASK) | CONT_TAG;
                  cmd.byte2 = (cp_next[7:0] & CONT_MASK) | CONT_TAG;
                  cmd.count = 2'd3;
               end
            end
            default: begin
               if (c == CH_QUOTE) begin
                  cmd.count  = 2'd1;
                  cmd.status = ST_CLOSE;
               end else if (c != CH_BSLASH) begin
                  cmd.byte0 = c;
                  cmd.count = 2'd1;
               end
            end
         endcase
      end
   end

   assign push     = accept && (cmd.count != 2'd0);
   assign push_cmd = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_PLAIN;
         cp_ff   <= 16'h0000;
         line_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         cp_ff   <= cp_in;
         line_ff <= line_in;
      end
   end

endmodule

// ----- src/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue: command queue between front and back end
// Four-entry FIFO; the head entry is visible without a read cycle.
// ----------------------------------------------------------------------------
module jsu_queue import jsu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output logic    full,
   output logic    empty,
   output cmd_type head
);

   cmd_type               entry_ff [QDEPTH];
   logic [QPTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QFILL_BITS-1:0] fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign full    = (fill_ff == QFILL_BITS'(QDEPTH));
   assign empty   = (fill_ff == '0);
   assign head    = entry_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- src/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back: result sequencer of the string unescaper
// Walks the head command's bytes into the registered result channel, one
// result per cycle when not stalled; retires the command after its final byte.
// ----------------------------------------------------------------------------
module jsu_back import jsu_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_empty,
   input  cmd_type   head,
   output logic      pop,
   jsu_rsp_if.source rsp_bus
);

   logic        valid_ff, valid_in;
   logic [7:0]  byte_ff, byte_in;
   status_type  status_ff, status_in;
   logic        last_ff, last_in;
   logic [15:0] line_ff, line_in;
   logic [1:0]  idx_ff, idx_in;
   logic        load, final_byte;

   // output register is free when empty or being taken this cycle
   assign load       = !valid_ff || rsp_bus.ready;
   assign final_byte = (idx_ff == head.count - 2'd1);
   assign pop        = load && !q_empty && final_byte;

   always_comb begin
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      line_in   = line_ff;
      idx_in    = idx_ff;
      if (load) begin
         valid_in  = !q_empty;
         status_in = head.status;
         last_in   = final_byte;
         line_in   = head.line;
         unique case (idx_ff)
            2'd0:    byte_in = head.byte0;
            2'd1:    byte_in = head.byte1;
            default: byte_in = head.byte2;
         endcase
         if (!q_empty) begin
            idx_in = final_byte ? 2'd0 : idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
      line_ff   <= line_in;
   end

   assign rsp_bus.valid       = valid_ff;
   assign rsp_bus.out_byte    = byte_ff;
   assign rsp_bus.status      = status_ff;
   assign rsp_bus.last        = last_ff;
   assign rsp_bus.line_number = line_ff;

endmodule

// ----- src/json_string_unescape.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape: JSON string body decoder with UTF-8 output
// Usage:
//   req_bus carries one byte of string text per transaction, starting just
//   after the opening quote. rsp_bus carries the results: decoded bytes
//   (status 0), string closed (status 1) or syntax error (status 2), with
//   last marking the final result of an input byte and line_number the
//   saturated count of raw line feeds so far.
//   Backslash, the u and the first three hex digits of \uXXXX give no
//   result; the fourth hex digit gives one to three UTF-8 bytes.
// Path: an accepted input byte is written as a command into the command
//   queue, and the queue head is then loaded into the registered output,
//   behind any commands queued ahead of it.
// Throughput: one input byte per cycle; one result per cycle while rsp_bus
//   ready is high, so a \u escape needing two or three output bytes holds
//   the back end until all of them are out. The four-entry command queue
//   absorbs those bursts; req_bus ready drops only while the queue is full.
// Reset: synchronous, clears escape state, line count, queue and output.
// Stall: while rsp_bus ready is low the output holds, the queue fills, and
//   then req_bus ready falls. No transaction is dropped.
// ----------------------------------------------------------------------------
module json_string_unescape import jsu_pkg::*; #(
   parameter int unsigned LINE_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   jsu_req_if.sink   req_bus,
   jsu_rsp_if.source rsp_bus
);

   logic    push, pop, q_full, q_empty;
   cmd_type push_cmd, head;

   jsu_front #(.LINE_BITS(LINE_BITS)) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .q_full   (q_full),
      .push     (push),
      .push_cmd (push_cmd)
   );

   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head     (head)
   );

   jsu_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .head    (head),
      .pop     (pop),
      .rsp_bus (rsp_bus)
   );

endmodule

// ----- src/jsu_checker.sv -----
// ----------------------------------------------------------------------------
// jsu_checker: port-level checks of the string unescaper
// Watches the result channel for ordering and framing rules.
// ----------------------------------------------------------------------------
module jsu_checker import jsu_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  out_byte,
   input logic [1:0]  status,
   input logic        last,
   input logic [15:0] line_number
);

   logic        seen_ff;
   logic [15:0] prev_line_ff;
   logic        rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (rsp_take) begin
         seen_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         prev_line_ff <= line_number;
      end
   end

   // hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_byte) && $stable(status)
         && $stable(last) && $stable(line_number))
      else $error("stalled result changed");

   // line count only advances across delivered results
   a_line_mono: assert property (@(posedge clock) disable iff (reset)
      rsp_take && seen_ff |-> line_number >= prev_line_ff)
      else $error("line_number went backwards");

   // close and error are single, empty results
   a_end_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (status == ST_CLOSE || status == ST_ERROR) |-> last && out_byte == 8'h00)
      else $error("close or error result malformed");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind json_string_unescape jsu_checker u_jsu_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .out_byte    (rsp_bus.out_byte),
   .status      (rsp_bus.status),
   .last        (rsp_bus.last),
   .line_number (rsp_bus.line_number)
);
